### rtl/core/lrr_pkg.sv
// Package for the ranged linear congruential generator.
// Holds the generator constants, the word width and the status struct
// shared by the serial units. Depends on nothing.
`default_nettype none

package lrr_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = $clog2(WordW);

    localparam logic [WordW-1:0] LcgMult = 32'd1103515245;
    localparam logic [WordW-1:0] LcgInc  = 32'd12345;
    localparam logic [WordW-1:0] FullSpan = {WordW{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

`default_nettype wire

### rtl/core/lcg_ranged_random.sv
// Top level of the ranged linear congruential generator.
// Sequences lrr_mul and lrr_div and holds the state and the output register.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_opcode, i_low_bound,
//                                                  i_high_bound, i_seed_value
//   output   out        o_out_valid / i_out_stall  o_draw_value
//
// A reseed item runs the serial multiplier on the seed, stores the new state and gives no output.
// A draw with equal bounds returns its bound directly; a full-span draw returns the new state.
// Any other draw runs the multiplier, then the divider, and returns low bound plus remainder.
// Reset clears the generator state to zero and empties the output register.
// A stalled output holds its item; a finished result waits until it is free.
`default_nettype none

module lcg_ranged_random
    import lrr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_opcode,
    input  wire logic [WordW-1:0] i_low_bound,
    input  wire logic [WordW-1:0] i_high_bound,
    input  wire logic [WordW-1:0] i_seed_value,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [WordW-1:0] o_draw_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [WordW-1:0] r_lcg_state, n_lcg_state;
    logic [WordW-1:0] r_lo, n_lo;
    logic [WordW-1:0] r_divisor, n_divisor;
    logic             r_is_seed, n_is_seed;
    logic             r_full, n_full;
    logic [WordW-1:0] r_result, n_result;
    logic             r_out_valid, n_out_valid;
    logic [WordW-1:0] r_draw_value, n_draw_value;

    logic             in_accept;
    logic [WordW-1:0] lo, hi, span;
    logic             mul_start, div_start;
    logic [WordW-1:0] mul_operand;
    logic [WordW-1:0] product, remainder;
    t_unit_sts        mul_sts, div_sts;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_low_bound < i_high_bound) begin
            lo = i_low_bound;
            hi = i_high_bound;
        end else begin
            lo = i_high_bound;
            hi = i_low_bound;
        end
        span = hi - lo;
    end

    always_comb begin
        n_state      = r_state;
        n_lcg_state  = r_lcg_state;
        n_lo         = r_lo;
        n_divisor    = r_divisor;
        n_is_seed    = r_is_seed;
        n_full       = r_full;
        n_result     = r_result;
        n_out_valid  = r_out_valid && i_out_stall;
        n_draw_value = r_draw_value;
        mul_start    = 1'b0;
        mul_operand  = r_lcg_state;
        div_start    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_is_seed = i_opcode;
                    n_lo      = lo;
                    n_divisor = span + 1'b1;
                    n_full    = (span == FullSpan);
                    if (i_opcode) begin
                        mul_start   = 1'b1;
                        mul_operand = i_seed_value;
                        n_state     = ST_MUL;
                    end else if (span == '0) begin
                        n_result = lo;
                        n_state  = ST_DONE;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_sts.done) begin
                    n_lcg_state = product;
                    if (r_is_seed) begin
                        n_state = ST_IDLE;
                    end else if (r_full) begin
                        n_result = product;
                        n_state  = ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    n_result = r_lo + remainder;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_draw_value = r_result;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcg_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcg_state <= n_lcg_state;
            r_out_valid <= n_out_valid;
        end
        r_lo         <= n_lo;
        r_divisor    <= n_divisor;
        r_is_seed    <= n_is_seed;
        r_full       <= n_full;
        r_result     <= n_result;
        r_draw_value <= n_draw_value;
    end

    lrr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_operand (mul_operand),
        .o_sts     (mul_sts),
        .o_product (product)
    );

    lrr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (product),
        .i_divisor   (r_divisor),
        .o_sts       (div_sts),
        .o_remainder (remainder)
    );

    assign o_out_valid  = r_out_valid;
    assign o_draw_value = r_draw_value;

    a_mul_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (mul_sts.busy || mul_sts.done))
        else $error("Multiplier idle while the sequencer waits on it.");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_sts.busy || div_sts.done))
        else $error("Divider idle while the sequencer waits on it.");

    a_div_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_divisor > 32'd1))
        else $error("Divider runs with a divisor below two.");

    a_equal_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_opcode && (i_low_bound == i_high_bound))
        |=> (r_state == ST_DONE) && (r_result == $past(i_low_bound))
            && $stable(r_lcg_state))
        else $error("Equal-bound draw did not return its bound directly.");

endmodule

`default_nettype wire

### rtl/core/lrr_mul.sv
// Shift-and-add unit that advances the generator state, one multiplier bit
// per cycle. Uses lrr_pkg for the constants and status.
`default_nettype none

module lrr_mul
    import lrr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WordW-1:0] i_operand,
    output t_unit_sts             o_sts,
    output logic      [WordW-1:0] o_product
);

    logic [WordW-1:0] r_acc, n_acc;
    logic [WordW-1:0] r_mcand, n_mcand;
    logic [WordW-1:0] r_mplier, n_mplier;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_acc    = LcgInc;
            n_mcand  = i_operand;
            n_mplier = LcgMult;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[WordW-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[WordW-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == CntW'(WordW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule

`default_nettype wire

### rtl/core/lrr_div.sv
// Restoring radix-2 remainder unit, one dividend bit per cycle. Uses lrr_pkg
// for the width and the status struct.
`default_nettype none

module lrr_div
    import lrr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WordW-1:0] i_dividend,
    input  wire logic [WordW-1:0] i_divisor,
    output t_unit_sts             o_sts,
    output logic      [WordW-1:0] o_remainder
);

    logic [WordW-1:0] r_rem, n_rem;
    logic [WordW-1:0] r_num, n_num;
    logic [WordW-1:0] r_den, n_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WordW:0]   trial;
    logic [WordW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_num[WordW-1]};
        diff   = trial - {1'b0, r_den};
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_num  = i_dividend;
            n_den  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[WordW-1:0];
            end else begin
                n_rem = trial[WordW-1:0];
            end
            n_num = {r_num[WordW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(WordW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_sts.busy   = r_busy;
    assign o_sts.done   = r_done;
    assign o_remainder  = r_rem;

endmodule

`default_nettype wire
